// ===== hw/rtl/pett_pkg.sv =====
// Shared constants and helpers for the periodic event timer table.
package pett_pkg;

    // Table size and the width of a slot index.
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Field widths of the transactions.
    localparam int CMD_W    = 2;
    localparam int PERIOD_W = 32;
    localparam int ID_W     = 8;
    localparam int KIND_W   = 3;
    localparam int OSLOT_W  = 3;

    // Width of one table entry in the timer memory: reload value over countdown.
    localparam int ENTRY_W  = 2 * PERIOD_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd3;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_REGISTERED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL         = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNREGISTERED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED        = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEARED      = 3'd5;

    typedef logic [SLOT_W-1:0] t_slot_idx;

    // The reported slot carries the low bits of the slot index.
    function automatic logic [OSLOT_W-1:0] to_out_slot(input t_slot_idx idx);
        return OSLOT_W'(idx);
    endfunction

endpackage

// ===== hw/rtl/pett_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pett_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/periodic_event_timer_table.sv =====
// Periodic event timer table: busy flags in flip-flops, countdown and reload values in one RAM.
// Register, unregister and clear give their result in the cycle after acceptance.
// A tick sweeps the timer RAM one slot per cycle while the output is not stalled, limited by the
// single read port of the RAM through which each entry is read.
// Fired results come in ascending slot order; a tick with no fired slot gives no transaction.
// Synchronous active-low reset clears all busy flags, the output and the sweep; the RAM needs none.
module periodic_event_timer_table
    import pett_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [PERIOD_W-1:0] i_period_ticks,
    input  logic [ID_W-1:0]     i_event_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KIND_W-1:0]   o_kind,
    output logic [OSLOT_W-1:0]  o_slot,
    output logic                o_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam t_slot_idx LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    logic [1:0]           r_state, n_state;
    logic [NUM_SLOTS-1:0] r_busy, n_busy;
    t_slot_idx            r_idx, n_idx;
    logic                 r_pend_v, n_pend_v;
    t_slot_idx            r_pend_slot, n_pend_slot;

    logic                 r_out_v, n_out_v;
    logic [KIND_W-1:0]    r_out_kind, n_out_kind;
    logic [OSLOT_W-1:0]   r_out_slot, n_out_slot;
    logic                 r_out_last, n_out_last;

    logic                 out_free;
    logic                 in_acc;
    logic                 free_found;
    t_slot_idx            free_idx;

    logic                 ram_we, ram_re;
    t_slot_idx            ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    logic [PERIOD_W-1:0]  cd, reload, cd_dec;
    logic                 active, fire, advance;

    // Timer memory: reload value in the upper half, countdown in the lower half.
    pett_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake on both sides.
    assign out_free   = !r_out_v || !i_out_stall;
    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Evaluation of the slot whose entry has just been read.
    assign cd      = ram_rdata[PERIOD_W-1:0];
    assign reload  = ram_rdata[ENTRY_W-1:PERIOD_W];
    assign cd_dec  = cd - PERIOD_W'(1);
    assign active  = r_busy[r_idx] && (cd != '0);
    assign fire    = active && (cd_dec == '0);
    assign advance = !(fire && r_pend_v) || out_free;

    // Control, memory access and result selection.
    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_out_v     = r_out_v && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = {reload, fire ? reload : cd_dec};
        ram_re      = 1'b0;
        ram_raddr   = r_idx + SLOT_W'(1);

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_out_slot = '0;
                    n_out_last = 1'b1;
                    case (i_command)
                        CMD_REGISTER: begin
                            n_out_v = 1'b1;
                            if (free_found) begin
                                n_busy[free_idx] = 1'b1;
                                ram_we           = 1'b1;
                                ram_waddr        = free_idx;
                                ram_wdata        = {i_period_ticks, i_period_ticks};
                                n_out_kind       = KIND_REGISTERED;
                                n_out_slot       = to_out_slot(free_idx);
                            end else begin
                                n_out_kind = KIND_FULL;
                            end
                        end
                        CMD_UNREGISTER: begin
                            n_out_v = 1'b1;
                            if (i_event_id < ID_W'(NUM_SLOTS)) begin
                                n_busy[i_event_id[SLOT_W-1:0]] = 1'b0;
                                n_out_kind = KIND_UNREGISTERED;
                            end else begin
                                n_out_kind = KIND_INVALID;
                            end
                        end
                        CMD_TICK: begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_pend_v  = 1'b0;
                            n_state   = ST_EVAL;
                        end
                        default: begin
                            n_out_v    = 1'b1;
                            n_busy     = '0;
                            n_out_kind = KIND_CLEARED;
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                if (advance) begin
                    ram_we = active;
                    // A new fire pushes the previous one out; it is not the last.
                    if (fire) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_kind = KIND_FIRED;
                            n_out_slot = to_out_slot(r_pend_slot);
                            n_out_last = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FLUSH;
                    end else begin
                        ram_re = 1'b1;
                        n_idx  = r_idx + SLOT_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                // The held fire is the final result of the tick.
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_kind = KIND_FIRED;
                    n_out_slot = to_out_slot(r_pend_slot);
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_slot <= n_pend_slot;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_out_v;
    assign o_kind      = r_out_kind;
    assign o_slot      = r_out_slot;
    assign o_last      = r_out_last;

endmodule

// ===== hw/rtl/pett_checker.sv =====
// Port-level checker for the periodic event timer table, with its bind statement.
module pett_checker
    import pett_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [CMD_W-1:0]    i_command,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [KIND_W-1:0]   o_kind,
    input logic [OSLOT_W-1:0]  o_slot,
    input logic                o_last
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_slot)
            && $stable(o_last))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Only registered and fired results carry a slot, and the others are always final.
    a_slot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_REGISTERED && o_kind != KIND_FIRED
            |-> o_slot == '0 && o_last)
        else $error("slot or last wrong for this kind");

    // Any command other than a tick gives its single result in the next cycle.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_command != CMD_TICK |=> o_out_valid && o_last
            && o_kind != KIND_FIRED)
        else $error("missing result for a non-tick command");

    // Result kinds stay within the defined codes.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= KIND_CLEARED)
        else $error("undefined result kind");

endmodule

bind periodic_event_timer_table pett_checker u_pett_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_slot      (o_slot),
    .o_last      (o_last)
);

// ===== sim/periodic_event_timer_table_tb.sv =====
// Self-checking testbench for the periodic event timer table, with its own model of the slot table.
module periodic_event_timer_table_tb;
    import pett_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Long receiver hold-off, no-progress limit and the quiet tail after the last result.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 4 * (NUM_SLOTS + 2);
    localparam int RANDOM_ITEMS   = 90;
    localparam int UNPACED_ITEMS  = 30;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [OSLOT_W-1:0] slot;
        logic               last;
    } t_timer_result;

    // Clock, reset and the ports of the block.
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command      = CMD_TICK;
    logic [PERIOD_W-1:0] i_period_ticks = '0;
    logic [ID_W-1:0]     i_event_id     = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [KIND_W-1:0]   o_kind;
    logic [OSLOT_W-1:0]  o_slot;
    logic                o_last;

    // Own copy of the timer table.
    logic                slot_taken [NUM_SLOTS];
    logic [PERIOD_W-1:0] ticks_left [NUM_SLOTS];
    logic [PERIOD_W-1:0] reload_ticks [NUM_SLOTS];

    t_timer_result pending_results [$];

    // Traffic shaping controls.
    bit gaps_on      = 1'b0;
    bit stall_random = 1'b0;
    bit hold_request = 1'b0;
    int hold_count   = 0;
    int stall_left   = 0;

    // Run statistics.
    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int fired_checked   = 0;
    int full_checked    = 0;
    int most_fired      = 0;
    int idle_cycles     = 0;

    periodic_event_timer_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_period_ticks (i_period_ticks),
        .i_event_id     (i_event_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_slot         (o_slot),
        .o_last         (o_last)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Periods are mostly small so that slots fire often; zero and huge values appear too.
    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Apply one command to the table copy and queue the results it causes.
    task automatic predict_timer_step(input logic [CMD_W-1:0] cmd,
                                      input logic [PERIOD_W-1:0] period,
                                      input logic [ID_W-1:0] id);
        t_timer_result step_out [$];
        t_timer_result res;
        int free_slot;
        int fired;
        free_slot = -1;
        fired     = 0;
        res.kind  = KIND_REGISTERED;
        res.slot  = '0;
        res.last  = 1'b0;
        case (cmd)
            CMD_REGISTER: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (!slot_taken[s] && free_slot < 0) free_slot = s;
                end
                if (free_slot >= 0) begin
                    slot_taken[free_slot]   = 1'b1;
                    ticks_left[free_slot]   = period;
                    reload_ticks[free_slot] = period;
                    res.kind = KIND_REGISTERED;
                    res.slot = OSLOT_W'(free_slot);
                end else begin
                    res.kind = KIND_FULL;
                end
                step_out.push_back(res);
            end
            CMD_UNREGISTER: begin
                if (id < NUM_SLOTS) begin
                    slot_taken[id]   = 1'b0;
                    ticks_left[id]   = '0;
                    reload_ticks[id] = '0;
                    res.kind = KIND_UNREGISTERED;
                end else begin
                    res.kind = KIND_INVALID;
                end
                step_out.push_back(res);
            end
            CMD_TICK: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (slot_taken[s] && ticks_left[s] != '0) begin
                        ticks_left[s] = ticks_left[s] - 1'b1;
                        if (ticks_left[s] == '0) begin
                            res.kind = KIND_FIRED;
                            res.slot = OSLOT_W'(s);
                            step_out.push_back(res);
                            ticks_left[s] = reload_ticks[s];
                            fired++;
                        end
                    end
                end
                if (fired > most_fired) most_fired = fired;
            end
            default: begin
                foreach (slot_taken[s]) begin
                    slot_taken[s]   = 1'b0;
                    ticks_left[s]   = '0;
                    reload_ticks[s] = '0;
                end
                res.kind = KIND_CLEARED;
                step_out.push_back(res);
            end
        endcase
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[k]) pending_results.push_back(step_out[k]);
    endtask

    // Offer one command transaction and hold it until the block takes it.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [PERIOD_W-1:0] period,
                             input logic [ID_W-1:0] id);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_period_ticks <= period;
        i_event_id     <= id;
        do @(posedge i_clk); while (o_in_stall);
        predict_timer_step(cmd, period, id);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, $urandom, ID_W'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One random command: ticks dominate, clears are rare.
    task automatic send_random_item();
        int pick;
        logic [ID_W-1:0] id;
        pick = $urandom_range(0, 99);
        id   = ($urandom_range(0, 4) != 0) ? ID_W'($urandom_range(0, NUM_SLOTS - 1))
                                           : ID_W'($urandom_range(0, 255));
        if (pick < 50)
            send_tick();
        else if (pick < 78)
            send_item(CMD_REGISTER, pick_period(), ID_W'($urandom_range(0, 255)));
        else if (pick < 95)
            send_item(CMD_UNREGISTER, $urandom, id);
        else
            send_item(CMD_CLEAR, $urandom, ID_W'($urandom_range(0, 255)));
    endtask

    // Directed walk through the corner cases of the table.
    task automatic test_directed();
        gaps_on      = 1'b1;
        stall_random = 1'b1;
        // Freeing a slot that was never taken, and ids past the table.
        send_item(CMD_UNREGISTER, '0, '0);
        send_item(CMD_UNREGISTER, '1, ID_W'(NUM_SLOTS));
        send_item(CMD_UNREGISTER, '0, '1);
        // A tick on an empty table gives nothing.
        send_tick();
        // Period one, period zero, the largest period and period two.
        send_item(CMD_REGISTER, PERIOD_W'(1), '1);
        send_item(CMD_REGISTER, '0, '0);
        send_item(CMD_REGISTER, '1, '0);
        send_item(CMD_REGISTER, PERIOD_W'(2), '0);
        send_tick();
        send_tick();
        // Fill the table, then overflow it.
        for (int s = 4; s < NUM_SLOTS; s++) send_item(CMD_REGISTER, PERIOD_W'(1), '0);
        send_item(CMD_REGISTER, PERIOD_W'(5), '0);
        send_tick();
        // Free the top slot and the period-zero slot, reuse one, then clear everything.
        send_item(CMD_UNREGISTER, '0, ID_W'(NUM_SLOTS - 1));
        send_item(CMD_REGISTER, PERIOD_W'(3), '0);
        send_item(CMD_UNREGISTER, '0, ID_W'(1));
        send_tick();
        send_item(CMD_CLEAR, '1, '1);
        send_tick();
        wait_until_drained();
    endtask

    // Random traffic with idling on both sides.
    task automatic test_random_traffic();
        gaps_on      = 1'b1;
        stall_random = 1'b1;
        repeat (RANDOM_ITEMS) send_random_item();
    endtask

    // Full table firing on every tick while the receiver holds off for a long stretch.
    task automatic test_output_backpressure();
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        send_item(CMD_CLEAR, '0, '0);
        repeat (NUM_SLOTS) send_item(CMD_REGISTER, PERIOD_W'(1), '0);
        send_item(CMD_REGISTER, PERIOD_W'(1), '0);
        repeat (16) send_tick();
        wait_until_drained();
    endtask

    // After a full pause, a stretch with no idling on either side.
    task automatic test_unpaced_traffic();
        wait_until_drained();
        gaps_on      = 1'b0;
        stall_random = 1'b0;
        repeat (UNPACED_ITEMS) send_random_item();
        wait_until_drained();
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Receiver stall: long hold-off on request, otherwise random or off.
    always @(negedge i_clk) begin
        if (hold_request) begin
            i_out_stall <= 1'b1;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_count   <= 0;
                hold_request <= 1'b0;
            end else begin
                hold_count <= hold_count + 1;
            end
        end else if (!stall_random) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= pick_gap();
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 6);
        end
    end

    // Check each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, actual kind %0d slot %0d last %0d",
                         $time, o_kind, o_slot, o_last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", want.kind, o_kind);
                compare_field("slot", want.slot, o_slot);
                compare_field("last", want.last, o_last);
                results_checked++;
                if (want.kind == KIND_FIRED) fired_checked++;
                if (want.kind == KIND_FULL) full_checked++;
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        foreach (slot_taken[s]) begin
            slot_taken[s]   = 1'b0;
            ticks_left[s]   = '0;
            reload_ticks[s] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_unpaced_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     pending_results.size());
            error_count++;
        end
        $display("Sent %0d commands; checked %0d results, %0d of them fired and %0d table full.",
                 items_sent, results_checked, fired_checked, full_checked);
        $display("Largest tick burst: %0d fired slots; mismatches found: %0d.",
                 most_fired, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
